// File: hw/rtl/rrqs_pkg.sv
// types and constants shared by the round-robin quantum scheduler
package rrqs_pkg;

   localparam int SLOTS  = 32;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_ADD  = 2'd1,
      CMD_READ = 2'd2
   } rrqs_cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } rrqs_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD_WAIT,
      ST_CUR_CHK,
      ST_SCAN,
      ST_UPD,
      ST_DONE
   } rrqs_state_type;

   typedef struct packed {
      rrqs_cmd_type cmd;
      logic [15:0]  burst_time;
      logic [4:0]   entry_index;
   } rrqs_req_type;

   typedef struct packed {
      rrqs_status_type status;
      logic            served_valid;
      logic [4:0]      served_slot;
      logic [31:0]     time_now;
      logic [5:0]      job_count;
      logic [15:0]     entry_remaining;
      logic [31:0]     entry_wait;
      logic [31:0]     entry_turnaround;
      logic [31:0]     entry_arrival;
   } rrqs_rsp_type;

   typedef struct packed {
      logic [15:0] remaining;
      logic [31:0] wait_cnt;
      logic [31:0] turnaround;
      logic [31:0] arrival;
   } rrqs_entry_type;

endpackage

// File: hw/rtl/round_robin_quantum_scheduler_core.sv
// round-robin time-slice scheduler with its job table in one synchronous memory
// a tick reads the current slot and, if its slice has expired, scans cyclically for
// the next job; when a job is served it then does a read-modify-write pass over all
// jobs through the table's one read port and one write port
// one command in flight; the next beat is taken while a result waits on rsp_stall
// synchronous reset clears time, slice, job count, current slot and sets quantum to 1
module round_robin_quantum_scheduler_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rrqs_pkg::rrqs_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rrqs_pkg::rrqs_rsp_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_data
);
   import rrqs_pkg::*;

   rrqs_state_type state_ff, state_in;
   rrqs_req_type   req_ff, req_in;
   rrqs_rsp_type   res_ff, res_in;
   rrqs_rsp_type   rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [7:0]        quantum_ff, quantum_in;
   logic [CNT_W-1:0]  job_total_ff, job_total_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic [7:0]        slice_ff, slice_in;
   logic [31:0]       time_ff, time_in;

   logic [SLOT_W-1:0] scan_addr_ff, scan_addr_in;
   logic [SLOT_W-1:0] first_ff, first_in;
   logic [SLOT_W-1:0] probe_slot_ff, probe_slot_in;
   logic              probe_valid_ff, probe_valid_in;
   logic [CNT_W-1:0]  probe_num_ff, probe_num_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [SLOT_W-1:0] wr_idx_ff, wr_idx_in;
   logic              wr_valid_ff, wr_valid_in;

   rrqs_entry_type    job_mem_ff [SLOTS];
   rrqs_entry_type    rd_data_ff;
   logic [SLOT_W-1:0] mem_ra;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_wa;
   rrqs_entry_type    mem_wd;

   logic expired;
   logic probe_hit;
   logic probe_last;
   logic upd_issue;
   logic upd_last;
   logic out_free;
   logic table_full;
   logic idx_bad;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                  input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] inc;
      inc = CNT_W'(s) + CNT_W'(1);
      return (inc == n) ? '0 : inc[SLOT_W-1:0];
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   function automatic rrqs_entry_type charge(input rrqs_entry_type e, input logic served);
      rrqs_entry_type r;
      r = e;
      if (served) begin
         r.remaining  = e.remaining - 16'd1;
         r.turnaround = sat_inc(e.turnaround);
      end else if (e.remaining != '0) begin
         r.wait_cnt   = sat_inc(e.wait_cnt);
         r.turnaround = sat_inc(e.turnaround);
      end
      return r;
   endfunction

   assign expired    = (slice_ff >= quantum_ff) || (CNT_W'(cur_ff) >= job_total_ff) ||
                       (rd_data_ff.remaining == '0);
   assign probe_hit  = probe_valid_ff && (rd_data_ff.remaining != '0);
   assign probe_last = probe_valid_ff && (probe_num_ff + CNT_W'(1) == job_total_ff);
   assign upd_issue  = rd_idx_ff < job_total_ff;
   assign upd_last   = wr_valid_ff && (CNT_W'(wr_idx_ff) + CNT_W'(1) == job_total_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign table_full = job_total_ff == CNT_W'(SLOTS);
   assign idx_bad    = 32'(req_ff.entry_index) >= 32'(job_total_ff);

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (req_ff.cmd)
               CMD_TICK: state_in = ST_CUR_CHK;
               CMD_READ: state_in = idx_bad ? ST_DONE : ST_RD_WAIT;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_RD_WAIT: state_in = ST_DONE;
         ST_CUR_CHK: begin
            if (!expired) state_in = ST_UPD;
            else if (job_total_ff == '0) state_in = ST_DONE;
            else state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (probe_hit) state_in = ST_UPD;
            else if (probe_last) state_in = ST_DONE;
         end
         ST_UPD: begin
            if (upd_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in         = req_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      quantum_in     = (csr_valid && csr_ready) ? csr_data : quantum_ff;
      job_total_in   = job_total_ff;
      cur_in         = cur_ff;
      slice_in       = slice_ff;
      time_in        = time_ff;
      scan_addr_in   = scan_addr_ff;
      first_in       = first_ff;
      probe_slot_in  = probe_slot_ff;
      probe_valid_in = 1'b0;
      probe_num_in   = probe_num_ff;
      rd_idx_in      = rd_idx_ff;
      wr_idx_in      = wr_idx_ff;
      wr_valid_in    = 1'b0;
      mem_ra         = cur_ff;
      mem_we         = 1'b0;
      mem_wa         = wr_idx_ff;
      mem_wd         = charge(rd_data_ff, wr_idx_ff == cur_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) req_in = req_data;
         end
         ST_DECODE: begin
            res_in = '0;
            case (req_ff.cmd)
               CMD_TICK: begin
                  time_in  = sat_inc(time_ff);
                  slice_in = (slice_ff < 8'd255) ? slice_ff + 8'd1 : slice_ff;
               end
               CMD_ADD: begin
                  if (table_full) begin
                     res_in.status = STAT_FULL;
                  end else begin
                     mem_we             = 1'b1;
                     mem_wa             = job_total_ff[SLOT_W-1:0];
                     mem_wd.remaining   = req_ff.burst_time;
                     mem_wd.wait_cnt    = '0;
                     mem_wd.turnaround  = '0;
                     mem_wd.arrival     = time_ff;
                     res_in.served_slot = 5'(job_total_ff);
                     job_total_in       = job_total_ff + CNT_W'(1);
                  end
               end
               CMD_READ: begin
                  if (idx_bad) res_in.status = STAT_RANGE;
                  else mem_ra = SLOT_W'(req_ff.entry_index);
               end
               default: ;
            endcase
         end
         ST_RD_WAIT: begin
            res_in.entry_remaining  = rd_data_ff.remaining;
            res_in.entry_wait       = rd_data_ff.wait_cnt;
            res_in.entry_turnaround = rd_data_ff.turnaround;
            res_in.entry_arrival    = rd_data_ff.arrival;
         end
         ST_CUR_CHK: begin
            rd_idx_in = '0;
            if (!expired) begin
               res_in.served_valid = 1'b1;
               res_in.served_slot  = 5'(cur_ff);
            end else begin
               slice_in     = '0;
               scan_addr_in = next_slot(cur_ff, job_total_ff);
               first_in     = next_slot(cur_ff, job_total_ff);
               probe_num_in = '0;
            end
         end
         ST_SCAN: begin
            mem_ra         = scan_addr_ff;
            scan_addr_in   = next_slot(scan_addr_ff, job_total_ff);
            probe_slot_in  = scan_addr_ff;
            probe_valid_in = 1'b1;
            if (probe_hit) begin
               cur_in              = probe_slot_ff;
               res_in.served_valid = 1'b1;
               res_in.served_slot  = 5'(probe_slot_ff);
               probe_valid_in      = 1'b0;
            end else if (probe_valid_ff) begin
               probe_num_in = probe_num_ff + CNT_W'(1);
               if (probe_last) begin
                  cur_in         = first_ff;
                  probe_valid_in = 1'b0;
               end
            end
         end
         ST_UPD: begin
            if (upd_issue) begin
               mem_ra      = rd_idx_ff[SLOT_W-1:0];
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
               wr_idx_in   = rd_idx_ff[SLOT_W-1:0];
               wr_valid_in = 1'b1;
            end
            if (wr_valid_ff) mem_we = 1'b1;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in           = res_ff;
               rsp_in.time_now  = time_ff;
               rsp_in.job_count = 6'(job_total_ff);
               rsp_valid_in     = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // job table
   always_ff @(posedge clock) begin
      if (mem_we) job_mem_ff[mem_wa] <= mem_wd;
      rd_data_ff <= job_mem_ff[mem_ra];
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
      scan_addr_ff  <= scan_addr_in;
      first_ff      <= first_in;
      probe_slot_ff <= probe_slot_in;
      probe_num_ff  <= probe_num_in;
      rd_idx_ff     <= rd_idx_in;
      wr_idx_ff     <= wr_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         quantum_ff     <= 8'd1;
         job_total_ff   <= '0;
         cur_ff         <= '0;
         slice_ff       <= '0;
         time_ff        <= '0;
         probe_valid_ff <= 1'b0;
         wr_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         quantum_ff     <= quantum_in;
         job_total_ff   <= job_total_in;
         cur_ff         <= cur_in;
         slice_ff       <= slice_in;
         time_ff        <= time_in;
         probe_valid_ff <= probe_valid_in;
         wr_valid_ff    <= wr_valid_in;
      end
   end

   // update pass never reads the entry it is writing back
   a_upd_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && wr_valid_ff && upd_issue) |-> wr_idx_ff != rd_idx_ff[SLOT_W-1:0])
      else $error("update pass read and write hit the same slot");

   a_job_total_range: assert property (@(posedge clock) disable iff (reset)
      job_total_ff <= CNT_W'(SLOTS))
      else $error("job count beyond table size");

   a_cur_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && job_total_ff != '0) |-> CNT_W'(cur_ff) < job_total_ff)
      else $error("current slot outside the job table");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result beat raised outside the done state");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> probe_num_ff < job_total_ff)
      else $error("scan ran past the job count");

endmodule
